@@ hw/rtl/line_edit_buffer_unit_defines.svh @@
// Assertion macros for the line edit buffer unit.
// Used by the top level only; no other dependencies.
`ifndef LINE_EDIT_BUFFER_UNIT_DEFINES_SVH
`define LINE_EDIT_BUFFER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define LEB_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define LEB_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define LEB_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define LEB_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

@@ hw/rtl/leb_pkg.sv @@
// Shared types, constants and codes for the line edit buffer.
// No dependencies.
package leb_pkg;
  localparam int MaxLen = 256;
  localparam int AW = $clog2(MaxLen);
  localparam int PW = $clog2(MaxLen + 1);
  localparam int CW = 21;

  typedef enum logic [3:0] {
    OP_INSERT = 4'd0, OP_HOME = 4'd1, OP_END = 4'd2, OP_NEXT = 4'd3, OP_PREV = 4'd4,
    OP_PWORD = 4'd5, OP_NWORD = 4'd6, OP_ERASE_ALL = 4'd7, OP_ERASE_NEXT = 4'd8,
    OP_ERASE_PREV = 4'd9, OP_ERASE_NWORD = 4'd10, OP_ERASE_PWORD = 4'd11,
    OP_ERASE_AFTER = 4'd12, OP_ERASE_BEFORE = 4'd13, OP_READ = 4'd14, OP_NOP = 4'd15
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_DECIDE, ST_INS_RD, ST_INS_WR, ST_INS_LAST,
    ST_CUT_RD, ST_CUT_WR, ST_READ_RD, ST_READ_WAIT, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_SCAN_START, CMD_SCAN_RD, CMD_SCAN_STEP, CMD_INS_START,
    CMD_INS_RD, CMD_INS_WR, CMD_INS_LAST, CMD_CUT_START, CMD_CUT_RD, CMD_CUT_WR,
    CMD_READ_RD, CMD_FINISH
  } cmd_t;

  typedef struct packed {
    logic is_prev;
    logic phase2;
    logic full;
    logic scan_end;
    logic scan_ws;
    logic ins_end;
    logic cut_end;
    op_t  op;
  } status_t;

  function automatic logic is_ws(input logic [CW-1:0] c);
    return (c >= CW'(9) && c <= CW'(13)) || c == CW'(32);
  endfunction
endpackage

@@ hw/rtl/line_edit_buffer_unit.sv @@
// Line edit buffer unit: one request per command, one result per request.
// Each request is decoded, then scans, shifts or reads entries as needed; its result is registered.
// One request at a time: no new request is taken while one is busy or its result waits.
// Reset (synchronous, active low) empties the text and homes the cursor.
// The text memory is not cleared; only entries below the length are read.
// Depends on leb_pkg, leb_ctrl, leb_dp and line_edit_buffer_unit_defines.svh.
`include "line_edit_buffer_unit_defines.svh"
module line_edit_buffer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic [20:0] in_code_point,
  input  logic [7:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_changed,
  output logic        out_overflow,
  output logic [8:0]  out_cursor_out,
  output logic [8:0]  out_length_out,
  output logic [20:0] out_char_out
);
  leb_pkg::cmd_t    cmd;
  leb_pkg::status_t st;
  logic             res_full;

  leb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .res_full(res_full), .st(st), .cmd(cmd)
  );

  leb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st), .in_opcode(in_opcode),
    .in_code_point(in_code_point), .in_read_index(in_read_index), .res_full(res_full),
    .out_stall(out_stall), .out_valid(out_valid), .out_changed(out_changed),
    .out_overflow(out_overflow), .out_cursor_out(out_cursor_out),
    .out_length_out(out_length_out), .out_char_out(out_char_out)
  );

  `LEB_ASSERT_IMP(a_cursor_le_len, clk, rst_n, out_valid, out_cursor_out <= out_length_out)
  `LEB_ASSERT_IMP(a_ovf_unchanged, clk, rst_n, out_valid && out_overflow, !out_changed)
  `LEB_ASSERT_NXT(a_no_accept_busy, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

@@ hw/rtl/leb_ctrl.sv @@
// Controller state machine for the line edit buffer.
// Depends on leb_pkg.
module leb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              res_full,
  input  leb_pkg::status_t  st,
  output leb_pkg::cmd_t     cmd
);
  leb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= leb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = leb_pkg::CMD_NONE;
    in_stall = 1'b1;
    case (state_r)
      leb_pkg::ST_IDLE: begin
        in_stall = res_full;
        if (in_valid && !res_full) begin
          cmd = leb_pkg::CMD_LOAD;
          state_nxt = leb_pkg::ST_DECIDE;
        end
      end
      leb_pkg::ST_DECIDE: begin
        case (st.op)
          leb_pkg::OP_INSERT: begin
            if (st.full) begin
              cmd = leb_pkg::CMD_FINISH;
              state_nxt = leb_pkg::ST_IDLE;
            end else begin
              cmd = leb_pkg::CMD_INS_START;
              state_nxt = leb_pkg::ST_INS_RD;
            end
          end
          leb_pkg::OP_PWORD, leb_pkg::OP_NWORD, leb_pkg::OP_ERASE_NWORD,
          leb_pkg::OP_ERASE_PWORD: begin
            cmd = leb_pkg::CMD_SCAN_START;
            state_nxt = leb_pkg::ST_SCAN_RD;
          end
          leb_pkg::OP_ERASE_NEXT, leb_pkg::OP_ERASE_PREV, leb_pkg::OP_ERASE_BEFORE: begin
            cmd = leb_pkg::CMD_CUT_START;
            state_nxt = leb_pkg::ST_CUT_RD;
          end
          leb_pkg::OP_READ: begin
            cmd = leb_pkg::CMD_READ_RD;
            state_nxt = leb_pkg::ST_READ_WAIT;
          end
          default: begin
            cmd = leb_pkg::CMD_FINISH;
            state_nxt = leb_pkg::ST_IDLE;
          end
        endcase
      end
      leb_pkg::ST_SCAN_RD: begin
        if (st.scan_end) begin
          if (st.op == leb_pkg::OP_ERASE_NWORD || st.op == leb_pkg::OP_ERASE_PWORD) begin
            cmd = leb_pkg::CMD_CUT_START;
            state_nxt = leb_pkg::ST_CUT_RD;
          end else begin
            cmd = leb_pkg::CMD_FINISH;
            state_nxt = leb_pkg::ST_IDLE;
          end
        end else begin
          cmd = leb_pkg::CMD_SCAN_RD;
          state_nxt = leb_pkg::ST_SCAN_CHK;
        end
      end
      leb_pkg::ST_SCAN_CHK: begin
        state_nxt = leb_pkg::ST_SCAN_RD;
        cmd = leb_pkg::CMD_SCAN_STEP;
      end
      leb_pkg::ST_INS_RD: begin
        if (st.ins_end) begin
          cmd = leb_pkg::CMD_INS_LAST;
          state_nxt = leb_pkg::ST_INS_LAST;
        end else begin
          cmd = leb_pkg::CMD_INS_RD;
          state_nxt = leb_pkg::ST_INS_WR;
        end
      end
      leb_pkg::ST_INS_WR: begin
        cmd = leb_pkg::CMD_INS_WR;
        state_nxt = leb_pkg::ST_INS_RD;
      end
      leb_pkg::ST_INS_LAST: begin
        cmd = leb_pkg::CMD_FINISH;
        state_nxt = leb_pkg::ST_IDLE;
      end
      leb_pkg::ST_CUT_RD: begin
        if (st.cut_end) begin
          cmd = leb_pkg::CMD_FINISH;
          state_nxt = leb_pkg::ST_IDLE;
        end else begin
          cmd = leb_pkg::CMD_CUT_RD;
          state_nxt = leb_pkg::ST_CUT_WR;
        end
      end
      leb_pkg::ST_CUT_WR: begin
        cmd = leb_pkg::CMD_CUT_WR;
        state_nxt = leb_pkg::ST_CUT_RD;
      end
      leb_pkg::ST_READ_WAIT: begin
        cmd = leb_pkg::CMD_FINISH;
        state_nxt = leb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = leb_pkg::ST_IDLE;
      end
    endcase
  end
endmodule

@@ hw/rtl/leb_dp.sv @@
// Datapath of the line edit buffer: text memory, cursor, length and result register.
// Depends on leb_pkg.
module leb_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  leb_pkg::cmd_t            cmd,
  output leb_pkg::status_t         st,
  input  logic [3:0]               in_opcode,
  input  logic [leb_pkg::CW-1:0]   in_code_point,
  input  logic [7:0]               in_read_index,
  output logic                     res_full,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic                     out_changed,
  output logic                     out_overflow,
  output logic [8:0]               out_cursor_out,
  output logic [8:0]               out_length_out,
  output logic [leb_pkg::CW-1:0]   out_char_out
);
  localparam int AW = leb_pkg::AW;
  localparam int PW = leb_pkg::PW;
  localparam int CW = leb_pkg::CW;

  logic [CW-1:0] mem [leb_pkg::MaxLen];
  logic [CW-1:0] rd_r;
  logic [PW-1:0] len_r, cur_r, len_nxt, cur_nxt;
  logic [PW-1:0] p_r, p_nxt;      // scan position / cut source / insert index
  logic [PW-1:0] gap_r, gap_nxt;
  logic          ph_r, ph_nxt;
  logic          stop_r, stop_nxt;
  leb_pkg::op_t  op_r, op_nxt;
  logic [CW-1:0] cp_r;
  logic [7:0]    ri_r;
  logic          ov_r, ov_nxt;
  logic          chg_r, chg_nxt;
  logic          vld_r, vld_nxt;
  logic [CW-1:0] ch_r, ch_nxt;
  logic [8:0]    oc_r, ol_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [CW-1:0] wd;
  logic          is_prev;
  logic [PW-1:0] sp;

  assign is_prev = (op_r == leb_pkg::OP_PWORD) || (op_r == leb_pkg::OP_ERASE_PWORD);
  assign sp = is_prev ? p_r - PW'(1) : p_r;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  always_comb begin
    st = '0;
    st.op = op_r;
    st.is_prev = is_prev;
    st.phase2 = ph_r;
    st.full = len_r >= PW'(leb_pkg::MaxLen);
    st.scan_end = stop_r || (is_prev ? (p_r == '0) : (p_r >= len_r));
    st.scan_ws = leb_pkg::is_ws(rd_r);
    st.ins_end = p_r <= cur_r;
    st.cut_end = (p_r >= len_r);
  end

  always_comb begin
    len_nxt = len_r; cur_nxt = cur_r; p_nxt = p_r; gap_nxt = gap_r; ph_nxt = ph_r;
    op_nxt = op_r; ov_nxt = ov_r; chg_nxt = chg_r; ch_nxt = ch_r; vld_nxt = vld_r;
    stop_nxt = stop_r;
    we = 1'b0; wa = p_r[AW-1:0]; wd = rd_r; ra = p_r[AW-1:0];
    if (vld_r && !out_stall) vld_nxt = 1'b0;
    case (cmd)
      leb_pkg::CMD_LOAD: begin
        op_nxt = leb_pkg::op_t'(in_opcode);
        ov_nxt = 1'b0; chg_nxt = 1'b0; ch_nxt = '0; ph_nxt = 1'b0;
      end
      leb_pkg::CMD_SCAN_START: begin
        p_nxt = cur_r; ph_nxt = 1'b0; stop_nxt = 1'b0;
      end
      leb_pkg::CMD_SCAN_RD: ra = sp[AW-1:0];
      leb_pkg::CMD_SCAN_STEP: begin
        // First phase skips whitespace going back or words going forward.
        if (is_prev) begin
          if (!ph_r && leb_pkg::is_ws(rd_r)) p_nxt = p_r - PW'(1);
          else if (!leb_pkg::is_ws(rd_r)) begin
            p_nxt = p_r - PW'(1); ph_nxt = 1'b1;
          end else begin
            stop_nxt = 1'b1;
          end
        end else begin
          if (!ph_r && !leb_pkg::is_ws(rd_r)) p_nxt = p_r + PW'(1);
          else if (leb_pkg::is_ws(rd_r)) begin
            p_nxt = p_r + PW'(1); ph_nxt = 1'b1;
          end else begin
            stop_nxt = 1'b1;
          end
        end
      end
      leb_pkg::CMD_INS_START: p_nxt = len_r;
      leb_pkg::CMD_INS_RD: ra = AW'(p_r - PW'(1));
      leb_pkg::CMD_INS_WR: begin
        we = 1'b1; wa = p_r[AW-1:0]; p_nxt = p_r - PW'(1);
      end
      leb_pkg::CMD_INS_LAST: begin
        we = 1'b1; wa = cur_r[AW-1:0]; wd = cp_r;
        len_nxt = len_r + PW'(1); cur_nxt = cur_r + PW'(1); chg_nxt = 1'b1;
      end
      leb_pkg::CMD_CUT_START: begin
        // p_r holds the scan stop point from the word scan when one ran.
        case (op_r)
          leb_pkg::OP_ERASE_NEXT: begin
            if (cur_r < len_r) begin
              gap_nxt = cur_r; p_nxt = cur_r + PW'(1); chg_nxt = 1'b1;
            end else p_nxt = len_r;
          end
          leb_pkg::OP_ERASE_PREV: begin
            if (cur_r != '0) begin
              gap_nxt = cur_r - PW'(1); p_nxt = cur_r;
              cur_nxt = cur_r - PW'(1); chg_nxt = 1'b1;
            end else p_nxt = len_r;
          end
          leb_pkg::OP_ERASE_BEFORE: begin
            if (cur_r != '0) begin
              gap_nxt = '0; p_nxt = cur_r; cur_nxt = '0; chg_nxt = 1'b1;
            end else p_nxt = len_r;
          end
          leb_pkg::OP_ERASE_NWORD: begin
            if (p_r != cur_r) begin
              gap_nxt = cur_r; chg_nxt = 1'b1;
            end else p_nxt = len_r;
          end
          default: begin
            if (p_r != cur_r) begin
              gap_nxt = p_r; p_nxt = cur_r; cur_nxt = p_r; chg_nxt = 1'b1;
            end else p_nxt = len_r;
          end
        endcase
      end
      leb_pkg::CMD_CUT_RD: ra = p_r[AW-1:0];
      leb_pkg::CMD_CUT_WR: begin
        we = 1'b1; wa = gap_r[AW-1:0];
        gap_nxt = gap_r + PW'(1); p_nxt = p_r + PW'(1);
      end
      leb_pkg::CMD_READ_RD: ra = AW'(ri_r);
      leb_pkg::CMD_FINISH: begin
        vld_nxt = 1'b1;
        case (op_r)
          leb_pkg::OP_INSERT: ov_nxt = !chg_r;
          leb_pkg::OP_HOME: if (cur_r != '0) begin cur_nxt = '0; chg_nxt = 1'b1; end
          leb_pkg::OP_END: if (cur_r < len_r) begin cur_nxt = len_r; chg_nxt = 1'b1; end
          leb_pkg::OP_NEXT:
            if (cur_r < len_r) begin cur_nxt = cur_r + PW'(1); chg_nxt = 1'b1; end
          leb_pkg::OP_PREV:
            if (cur_r != '0) begin cur_nxt = cur_r - PW'(1); chg_nxt = 1'b1; end
          leb_pkg::OP_PWORD, leb_pkg::OP_NWORD:
            if (p_r != cur_r) begin cur_nxt = p_r; chg_nxt = 1'b1; end
          leb_pkg::OP_ERASE_ALL: begin
            len_nxt = '0; cur_nxt = '0; chg_nxt = 1'b1;
          end
          leb_pkg::OP_ERASE_AFTER: begin len_nxt = cur_r; chg_nxt = 1'b1; end
          leb_pkg::OP_ERASE_NEXT, leb_pkg::OP_ERASE_PREV, leb_pkg::OP_ERASE_NWORD,
          leb_pkg::OP_ERASE_PWORD, leb_pkg::OP_ERASE_BEFORE:
            if (chg_r) len_nxt = gap_r;
          leb_pkg::OP_READ:
            if (PW'(ri_r) < len_r) ch_nxt = rd_r;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0; cur_r <= '0; vld_r <= 1'b0;
    end else begin
      len_r <= len_nxt; cur_r <= cur_nxt; vld_r <= vld_nxt;
    end
    p_r <= p_nxt;
    gap_r <= gap_nxt; ph_r <= ph_nxt; stop_r <= stop_nxt; op_r <= op_nxt; ov_r <= ov_nxt;
    chg_r <= chg_nxt; ch_r <= ch_nxt;
    if (cmd == leb_pkg::CMD_LOAD) begin
      cp_r <= in_code_point; ri_r <= in_read_index;
    end
    if (cmd == leb_pkg::CMD_FINISH) begin
      oc_r <= 9'(cur_nxt); ol_r <= 9'(len_nxt);
    end
  end

  assign res_full = vld_r;
  assign out_valid = vld_r;
  assign out_changed = chg_r;
  assign out_overflow = ov_r;
  assign out_cursor_out = oc_r;
  assign out_length_out = ol_r;
  assign out_char_out = ch_r;
endmodule

@@ tb/line_edit_buffer_unit_checker.sv @@
// Checker for the line edit buffer unit: watches both channels, predicts each result
// from its own copy of the text and cursor, and counts mismatches. Depends on leb_pkg.
module line_edit_buffer_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [3:0]  in_opcode,
  input  logic [20:0] in_code_point,
  input  logic [7:0]  in_read_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_changed,
  input  logic        out_overflow,
  input  logic [8:0]  out_cursor_out,
  input  logic [8:0]  out_length_out,
  input  logic [20:0] out_char_out,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic        changed;
    logic        overflow;
    logic [8:0]  cursor;
    logic [8:0]  length;
    logic [20:0] char_read;
  } edit_result_t;

  logic [20:0] text[leb_pkg::MaxLen];
  int unsigned used_len;
  int unsigned cur;
  edit_result_t expected_q[$];

  function automatic bit blank(logic [20:0] c);
    return (c >= 21'd9 && c <= 21'd13) || c == 21'd32;
  endfunction

  function automatic int unsigned word_back();
    int unsigned p;
    p = cur;
    while (p > 0 && blank(text[p-1])) p--;
    while (p > 0 && !blank(text[p-1])) p--;
    return p;
  endfunction

  function automatic int unsigned word_fwd();
    int unsigned p;
    p = cur;
    while (p < used_len && !blank(text[p])) p++;
    while (p < used_len && blank(text[p])) p++;
    return p;
  endfunction

  task automatic cut(int unsigned from, int unsigned upto);
    int unsigned gap;
    gap = upto - from;
    for (int unsigned i = upto; i < used_len; i++) text[i-gap] = text[i];
    used_len -= gap;
  endtask

  task automatic apply_edit(leb_pkg::op_t op, logic [20:0] cp, logic [7:0] idx);
    edit_result_t r;
    int unsigned p;
    r = '0;
    case (op)
      leb_pkg::OP_INSERT: begin
        if (used_len >= leb_pkg::MaxLen) begin
          r.overflow = 1;
        end else begin
          for (int unsigned i = used_len; i > cur; i--) text[i] = text[i-1];
          text[cur] = cp;
          used_len++;
          cur++;
          r.changed = 1;
        end
      end
      leb_pkg::OP_HOME: if (cur != 0) begin cur = 0; r.changed = 1; end
      leb_pkg::OP_END: if (cur < used_len) begin cur = used_len; r.changed = 1; end
      leb_pkg::OP_NEXT: if (cur < used_len) begin cur++; r.changed = 1; end
      leb_pkg::OP_PREV: if (cur > 0) begin cur--; r.changed = 1; end
      leb_pkg::OP_PWORD: begin
        p = word_back();
        if (p != cur) begin cur = p; r.changed = 1; end
      end
      leb_pkg::OP_NWORD: begin
        p = word_fwd();
        if (p != cur) begin cur = p; r.changed = 1; end
      end
      leb_pkg::OP_ERASE_ALL: begin used_len = 0; cur = 0; r.changed = 1; end
      leb_pkg::OP_ERASE_NEXT:
        if (cur < used_len) begin cut(cur, cur + 1); r.changed = 1; end
      leb_pkg::OP_ERASE_PREV:
        if (cur > 0) begin cut(cur - 1, cur); cur--; r.changed = 1; end
      leb_pkg::OP_ERASE_NWORD: begin
        p = word_fwd();
        if (p != cur) begin cut(cur, p); r.changed = 1; end
      end
      leb_pkg::OP_ERASE_PWORD: begin
        p = word_back();
        if (p != cur) begin cut(p, cur); cur = p; r.changed = 1; end
      end
      leb_pkg::OP_ERASE_AFTER: begin used_len = cur; r.changed = 1; end
      leb_pkg::OP_ERASE_BEFORE:
        if (cur > 0) begin cut(0, cur); cur = 0; r.changed = 1; end
      leb_pkg::OP_READ: if (idx < used_len) r.char_read = text[idx];
      default: ;
    endcase
    r.cursor = cur[8:0];
    r.length = used_len[8:0];
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    edit_result_t e;
    if (!rst_n) begin
      used_len = 0;
      cur = 0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Result with no request outstanding");
        end else begin
          e = expected_q.pop_front();
          if (e != {out_changed, out_overflow, out_cursor_out, out_length_out,
                    out_char_out}) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Mismatch: expected %0d %0d %0d %0d %h, got %0d %0d %0d %0d %h",
                       e.changed, e.overflow, e.cursor, e.length, e.char_read,
                       out_changed, out_overflow, out_cursor_out, out_length_out,
                       out_char_out);
          end
        end
      end
      if (in_valid && !in_stall)
        apply_edit(leb_pkg::op_t'(in_opcode), in_code_point, in_read_index);
    end
    pending = expected_q.size();
  end
endmodule

@@ tb/line_edit_buffer_unit_tb.sv @@
// Testbench top for the line edit buffer unit: drives directed and random edit requests
// under several idling phases. Uses leb_pkg, line_edit_buffer_unit and its checker.
module line_edit_buffer_unit_tb;
  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_opcode;
  logic [20:0] in_code_point;
  logic [7:0]  in_read_index;
  logic        out_valid;
  logic        out_stall;
  logic        out_changed;
  logic        out_overflow;
  logic [8:0]  out_cursor_out;
  logic [8:0]  out_length_out;
  logic [20:0] out_char_out;
  int          fail_count;
  int          pending;
  int          send_idle_pct;
  int          stall_pct;
  int          sent;

  line_edit_buffer_unit dut (.*);
  line_edit_buffer_unit_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  function automatic logic [20:0] pick_char();
    case ($urandom_range(5))
      0: return 21'd32;
      1: return 21'($urandom_range(13, 9));
      2: return 21'($urandom_range(1114111));
      3: return 21'($urandom_range(1, 0) ? 0 : 21'h1FFFFF);
      default: return 21'($urandom_range(126, 33));
    endcase
  endfunction

  // Holds one request until it is taken; idle cycles before it follow the phase.
  task automatic send(leb_pkg::op_t op, logic [20:0] cp, logic [7:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_opcode <= op;
    in_code_point <= cp;
    in_read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_random();
    int k;
    k = $urandom_range(99);
    if (k < 45) send(leb_pkg::OP_INSERT, pick_char(), '0);
    else if (k < 55) send(leb_pkg::OP_READ, '0, 8'($urandom_range(255)));
    else if (k < 57) send(leb_pkg::op_t'($urandom_range(15, 7)), pick_char(), 8'($urandom));
    else send(leb_pkg::op_t'($urandom_range(13, 1)), 21'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_opcode = '0;
    in_code_point = '0;
    in_read_index = '0;
    out_stall = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: empty-buffer edge cases, extreme code points, word moves, every opcode.
    for (int op = 1; op < 16; op++) send(leb_pkg::op_t'(op), '0, 8'hFF);
    send(leb_pkg::OP_INSERT, 21'h1FFFFF, '0);
    send(leb_pkg::OP_INSERT, 21'd0, '0);
    send(leb_pkg::OP_INSERT, 21'd32, '0);
    send(leb_pkg::OP_INSERT, 21'd9, '0);
    send(leb_pkg::OP_INSERT, 21'd65, '0);
    send(leb_pkg::OP_PWORD, '0, '0);
    send(leb_pkg::OP_NWORD, '0, '0);
    send(leb_pkg::OP_READ, '0, 8'd0);
    send(leb_pkg::OP_READ, '0, 8'd4);
    send(leb_pkg::OP_ERASE_PWORD, '0, '0);
    drain();
    // Fill the buffer to overflow, then read its top entry.
    for (int i = 0; i < 258; i++) send(leb_pkg::OP_INSERT, 21'($urandom_range(1114111)), '0);
    send(leb_pkg::OP_READ, '0, 8'hFF);
    send(leb_pkg::OP_ERASE_NWORD, '0, '0);
    send(leb_pkg::OP_HOME, '0, '0);
    send(leb_pkg::OP_ERASE_NWORD, '0, '0);
    send(leb_pkg::OP_ERASE_ALL, '0, '0);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 12 : 76) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 12 : 76) : 0;
      for (int i = 0; i < 40; i++) send_random();
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (50) @(posedge clk);
    $display("Ran %0d edit requests: every opcode, overflow at a full buffer,", sent);
    $display("word moves over mixed whitespace, under four idling phases.");
    if (fail_count == 0) $display("line_edit_buffer_unit_tb passed");
    else $display("line_edit_buffer_unit_tb failed");
    $finish;
  end

  initial begin
    #200000000;
    $display("line_edit_buffer_unit_tb failed");
    $finish;
  end
endmodule
